// File: hdl/wildcard_byte_pattern_scan_macros.svh
// Assertion macros used by the signature scan checker
`ifndef WILDCARD_BYTE_PATTERN_SCAN_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_MACROS_SVH

// same-cycle implication
`define WBPS_ASSERT_NOW(label, clk, rst, cond, expect_now, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_now)) \
    else $error(msg);

// next-cycle implication
`define WBPS_ASSERT_NEXT(label, clk, rst, cond, expect_next, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
    else $error(msg);

`endif

// File: hdl/wbps_pkg.sv
// Shared constants, types and register codes for the signature scan
package wbps_pkg;

  localparam int SIG_BYTES = 32;
  localparam int SIG_IDX_W = 5;
  localparam int BYTE_W = 8;
  localparam int WORD_W = 64;
  localparam int WORDS = 4;
  localparam int LEN_W = 6;
  localparam int OFFS_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int DEFAULT_MAX_PATTERN_BYTES = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_0_7,
    REG_PAT_8_15,
    REG_PAT_16_23,
    REG_PAT_24_31,
    REG_CARE,
    REG_LENGTH,
    REG_START,
    REG_END
  } reg_idx_t;

  typedef logic [SIG_BYTES-1:0][BYTE_W-1:0] sig_t;

  typedef struct packed {
    logic             shift;
    logic [LEN_W-1:0] length;
  } cell_ctrl_t;

  typedef struct packed {
    logic              found;
    logic [OFFS_W-1:0] match_offset;
  } result_t;

endpackage

// File: hdl/wbps_cell.sv
// One window cell: holds a byte, hands it on, compares its incoming byte
module wbps_cell #(
  parameter int CELL_POS = 0
) (
  input  logic                                  clk,
  input  wbps_pkg::cell_ctrl_t                  ctrl,
  input  logic [wbps_pkg::BYTE_W-1:0]           byte_in,
  input  wbps_pkg::sig_t                        sig,
  input  logic [wbps_pkg::SIG_BYTES-1:0]        care,
  output logic [wbps_pkg::BYTE_W-1:0]           byte_out,
  output logic                                  hit
);

  logic [wbps_pkg::BYTE_W-1:0]    window_byte;
  logic                           in_use;
  logic [wbps_pkg::LEN_W-1:0]     idx_full;
  logic [wbps_pkg::SIG_IDX_W-1:0] idx;

  assign in_use   = ctrl.length > wbps_pkg::LEN_W'(CELL_POS);
  assign idx_full = ctrl.length - wbps_pkg::LEN_W'(CELL_POS) - wbps_pkg::LEN_W'(1);
  assign idx      = idx_full[wbps_pkg::SIG_IDX_W-1:0];
  assign hit      = !in_use || !care[idx] || (byte_in == sig[idx]);
  assign byte_out = window_byte;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      window_byte <= byte_in;
    end
  end

endmodule

// File: hdl/wbps_result_queue.sv
// Two-slot result queue between the scan decision and the result channel
module wbps_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wbps_pkg::result_t push_data,
  input  logic              out_stall,
  output logic              out_valid,
  output wbps_pkg::result_t out_data,
  output logic              full
);

  wbps_pkg::result_t slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              pop;

  assign out_valid = count != 2'd0;
  assign full      = count == 2'd2;
  assign pop       = out_valid && !out_stall;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hdl/wildcard_byte_pattern_scan.sv
// Top level of the masked byte signature scan: config, cell row, offset tracking
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------
//  config   | cfg_we                    | cfg_index, cfg_data
//  request  | item_valid / item_stall   | data_byte, region_end
//  result   | result_valid/result_stall | found, match_offset
//
// One request per cycle unless stalled; the cell row shifts and compares on accept.
// A result is in the queue the cycle after the request that completes the first
// matching window or ends a region without one; the queue's slot register sets this.
// Reset clears offsets, flags, queue; config takes defaults; cells are not cleared.
// item_stall is high only while both result slots are occupied.
module wildcard_byte_pattern_scan #(
  parameter int MAX_PATTERN_BYTES = wbps_pkg::DEFAULT_MAX_PATTERN_BYTES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wbps_pkg::WORD_W-1:0]       cfg_data,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [wbps_pkg::BYTE_W-1:0]       data_byte,
  input  logic                              region_end,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              found,
  output logic [wbps_pkg::OFFS_W-1:0]       match_offset
);

  logic [wbps_pkg::WORD_W-1:0]    pattern_words [wbps_pkg::WORDS];
  logic [wbps_pkg::SIG_BYTES-1:0] care_mask;
  logic [wbps_pkg::LEN_W-1:0]     pattern_length;
  logic [wbps_pkg::OFFS_W-1:0]    scan_start;
  logic [wbps_pkg::OFFS_W-1:0]    scan_end;
  logic [wbps_pkg::OFFS_W-1:0]    bytes_seen;
  logic                           match_reported;

  wbps_pkg::sig_t                 sig;
  wbps_pkg::cell_ctrl_t           ctrl;
  logic [wbps_pkg::LEN_W-1:0]     used_len;
  logic [wbps_pkg::OFFS_W-1:0]    len_m1;
  logic [wbps_pkg::OFFS_W-1:0]    begin_offset;
  logic [wbps_pkg::BYTE_W-1:0]    cell_byte [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0]   hits;
  logic                           accept;
  logic                           queue_full;
  logic                           in_range;
  logic                           match_now;
  logic                           push;
  wbps_pkg::result_t              push_data;
  wbps_pkg::result_t              out_data;

  assign sig = {pattern_words[3], pattern_words[2], pattern_words[1], pattern_words[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < wbps_pkg::WORDS; w++) begin
        pattern_words[w] <= '0;
      end
      care_mask      <= '1;
      pattern_length <= wbps_pkg::LEN_W'(1);
      scan_start     <= '0;
      scan_end       <= '1;
    end else if (cfg_we) begin
      case (wbps_pkg::reg_idx_t'(cfg_index))
        wbps_pkg::REG_PAT_0_7:   pattern_words[0] <= cfg_data;
        wbps_pkg::REG_PAT_8_15:  pattern_words[1] <= cfg_data;
        wbps_pkg::REG_PAT_16_23: pattern_words[2] <= cfg_data;
        wbps_pkg::REG_PAT_24_31: pattern_words[3] <= cfg_data;
        wbps_pkg::REG_CARE:      care_mask <= cfg_data[wbps_pkg::SIG_BYTES-1:0];
        wbps_pkg::REG_LENGTH:    pattern_length <= cfg_data[wbps_pkg::LEN_W-1:0];
        wbps_pkg::REG_START:     scan_start <= cfg_data[wbps_pkg::OFFS_W-1:0];
        wbps_pkg::REG_END:       scan_end <= cfg_data[wbps_pkg::OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    used_len = pattern_length;
    if (pattern_length == '0) begin
      used_len = wbps_pkg::LEN_W'(1);
    end else if (pattern_length > wbps_pkg::LEN_W'(MAX_PATTERN_BYTES)) begin
      used_len = wbps_pkg::LEN_W'(MAX_PATTERN_BYTES);
    end
  end

  assign accept      = item_valid && !queue_full;
  assign item_stall  = queue_full;
  assign ctrl.shift  = accept;
  assign ctrl.length = used_len;

  for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
    logic [wbps_pkg::BYTE_W-1:0] byte_in;
    if (j == 0) begin : g_head
      assign byte_in = data_byte;
    end else begin : g_link
      assign byte_in = cell_byte[j-1];
    end
    wbps_cell #(
      .CELL_POS(j)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .byte_in  (byte_in),
      .sig      (sig),
      .care     (care_mask),
      .byte_out (cell_byte[j]),
      .hit      (hits[j])
    );
  end

  assign len_m1       = wbps_pkg::OFFS_W'(used_len) - wbps_pkg::OFFS_W'(1);
  assign begin_offset = bytes_seen - len_m1;
  assign in_range     = (bytes_seen >= len_m1) && (bytes_seen < scan_end) &&
                        (begin_offset >= scan_start);
  assign match_now    = !match_reported && in_range && (&hits);
  assign push         = accept && (match_now || (region_end && !match_reported));

  assign push_data.found        = match_now;
  assign push_data.match_offset = match_now ? begin_offset : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      match_reported <= 1'b0;
    end else if (accept) begin
      if (region_end) begin
        bytes_seen     <= '0;
        match_reported <= 1'b0;
      end else begin
        if (bytes_seen != '1) begin
          bytes_seen <= bytes_seen + wbps_pkg::OFFS_W'(1);
        end
        if (match_now) begin
          match_reported <= 1'b1;
        end
      end
    end
  end

  wbps_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_stall (result_stall),
    .out_valid (result_valid),
    .out_data  (out_data),
    .full      (queue_full)
  );

  assign found        = out_data.found;
  assign match_offset = out_data.match_offset;

endmodule

// File: hdl/wbps_checker.sv
// Port-level checks for the signature scan, bound to the top level
`include "wildcard_byte_pattern_scan_macros.svh"

module wbps_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_stall,
  input logic                           result_valid,
  input logic                           result_stall,
  input logic                           found,
  input logic [wbps_pkg::OFFS_W-1:0]    match_offset
);

  `WBPS_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(found) && $stable(match_offset), "stalled result changed")
  `WBPS_ASSERT_NOW(a_not_found_zero, clk, rst, result_valid && !found, match_offset == '0, "not-found result with nonzero offset")
  `WBPS_ASSERT_NOW(a_stall_needs_result, clk, rst, item_stall, result_valid, "request stalled with no result waiting")
  `WBPS_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !result_valid && !item_stall, "result or stall after reset")

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_checker (.*);
